@@ rtl/core/grid_bilinear_interpolator_unit_assert.svh @@
// Assertion macros for the grid bilinear interpolator.
// Expects clk and rst_n in the including scope.
`ifndef GRID_BILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define GBI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbi assertion failed");

// next-cycle implication
`define GBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbi assertion failed");

`endif

@@ rtl/core/gbi_pkg.sv @@
// Shared widths, defaults and control types of the grid bilinear interpolator.
// No dependencies.
package gbi_pkg;

    localparam int IDX_W          = 14;
    localparam int DATA_W         = 32;
    localparam int WGT_W          = 18;
    localparam int SIZE_W         = 8;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    typedef struct packed {
        logic clear;
        logic data_vld;
    } mac_ctrl_t;

endpackage

@@ rtl/core/grid_bilinear_interpolator_unit.sv @@
// Grid bilinear interpolator top level: APB registers, command sequencer,
// sample memory, index divider and multiply-accumulate. Depends on gbi_pkg and the gbi_* modules.
//
// Usage: a write word (command 0) stores sample_value at cell_index and gives no result.
// A query word (command 1) returns one result word; after acceptance it passes through
// the two-bit-per-cycle divider that splits cell_index into row and column, a step
// forming the row bases, four reads of the single-port sample memory (one per neighbor),
// the multiply-accumulate pipeline, a rounding step and the output register. A query
// past width * height, or one on an edge without wrap, gives value 0 with out_of_range
// set. The block works one query at a time; the output register lets the next word be
// accepted while a result waits. Configuration is APB at byte addresses 0, 4, 8, 12
// (width, height, wrap_x, wrap_y) and may only change while the block is idle.
module grid_bilinear_interpolator_unit #(
    parameter int MAX_WIDTH  = gbi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbi_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              command,
    input  logic [gbi_pkg::IDX_W-1:0]         cell_index,
    input  logic signed [gbi_pkg::DATA_W-1:0] sample_value,
    input  logic signed [gbi_pkg::WGT_W-1:0]  weight_0,
    input  logic signed [gbi_pkg::WGT_W-1:0]  weight_1,
    input  logic signed [gbi_pkg::WGT_W-1:0]  weight_2,
    input  logic signed [gbi_pkg::WGT_W-1:0]  weight_3,
    input  logic                              last_point,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [gbi_pkg::DATA_W-1:0] interpolated_value,
    output logic                              out_of_range,
    output logic                              last_point_out
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IW     = gbi_pkg::IDX_W;
    localparam int DW     = gbi_pkg::DATA_W;
    localparam int WW     = gbi_pkg::WGT_W;
    localparam int SW     = gbi_pkg::SIZE_W;
    localparam int LW     = 2 * gbi_pkg::SIZE_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_WRAP_X      = 2'd2,
        REG_WRAP_Y      = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_DRAIN,
        ST_ROUND,
        ST_PUT
    } state_t;

    // configuration
    logic [SW-1:0] grid_width_reg;
    logic [SW-1:0] grid_height_reg;
    logic          wrap_x_reg;
    logic          wrap_y_reg;
    logic          cfg_wr;
    reg_idx_t      cfg_sel;

    // sequencer
    state_t               state_reg;
    logic [1:0]           k_reg;
    logic                 rd_vld_reg;
    logic [1:0]           rd_k_reg;
    logic signed [WW-1:0] wgt_reg [4];
    logic                 last_reg;
    logic [LW-1:0]        base0_reg, base1_reg;
    logic [SW-1:0]        col_reg, ncol_reg;
    logic signed [DW-1:0] pend_value_reg;
    logic                 pend_oor_reg;
    logic                 rsp_valid_reg;
    logic signed [DW-1:0] value_reg;
    logic                 oor_reg;
    logic                 last_out_reg;

    logic [SW-1:0]        w_eff, h_eff;
    logic [LW-1:0]        area;
    logic                 accept;
    logic                 in_grid;
    logic                 in_depth;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [DW-1:0]        mem_rdata;
    logic [LW-1:0]        rd_addr;

    logic [IW-1:0]        div_quo;
    logic [SW-1:0]        div_rem;
    logic                 div_busy, div_done, div_start;
    logic [SW-1:0]        row;
    logic [SW:0]          ni_full, nj_full;
    logic                 ni_hit, nj_hit, edge_oor;
    logic [SW-1:0]        ncol, nrow;

    gbi_pkg::mac_ctrl_t   mac_ctrl;
    logic signed [DW-1:0] mac_result;
    logic                 put_load;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SW'(128);
            grid_height_reg <= SW'(128);
            wrap_x_reg      <= 1'b0;
            wrap_y_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[SW-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[SW-1:0];
                REG_WRAP_X:      wrap_x_reg      <= pwdata[0];
                REG_WRAP_Y:      wrap_y_reg      <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            REG_WRAP_X:      prdata = 32'(wrap_x_reg);
            REG_WRAP_Y:      prdata = 32'(wrap_y_reg);
        endcase
    end

    // ---------------- effective grid size ----------------
    always_comb
    begin
        priority if (grid_width_reg == '0)
            w_eff = SW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;

        priority if (grid_height_reg == '0)
            h_eff = SW'(1);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            h_eff = SW'(MAX_HEIGHT);
        else
            h_eff = grid_height_reg;
    end

    assign area      = LW'(w_eff) * LW'(h_eff);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_grid   = LW'(cell_index) < area;
    assign in_depth  = 32'(cell_index) < 32'(DEPTH);
    assign mem_we    = accept && (command == CMD_WRITE) && in_depth;
    assign div_start = accept && (command == CMD_QUERY) && in_grid;

    // ---------------- neighbor addressing ----------------
    assign row      = div_quo[SW-1:0];
    assign ni_full  = (SW+1)'(div_rem) + 1'b1;
    assign nj_full  = (SW+1)'(row) + 1'b1;
    assign ni_hit   = ni_full == (SW+1)'(w_eff);
    assign nj_hit   = nj_full == (SW+1)'(h_eff);
    assign edge_oor = (ni_hit && !wrap_x_reg) || (nj_hit && !wrap_y_reg);
    assign ncol     = ni_hit ? '0 : ni_full[SW-1:0];
    assign nrow     = nj_hit ? '0 : nj_full[SW-1:0];

    assign rd_addr  = (k_reg[1] ? base1_reg : base0_reg) + LW'(k_reg[0] ? ncol_reg : col_reg);
    assign mem_addr = mem_we ? ADDR_W'(cell_index) : ADDR_W'(rd_addr);

    assign mac_ctrl.clear    = (state_reg == ST_ADDR);
    assign mac_ctrl.data_vld = rd_vld_reg;

    assign put_load = (state_reg == ST_PUT) && (!rsp_valid_reg || rsp_ready);

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            rd_k_reg       <= '0;
            last_reg       <= 1'b0;
            base0_reg      <= '0;
            base1_reg      <= '0;
            col_reg        <= '0;
            ncol_reg       <= '0;
            pend_value_reg <= '0;
            pend_oor_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            value_reg      <= '0;
            oor_reg        <= 1'b0;
            last_out_reg   <= 1'b0;
            for (int n = 0; n < 4; n++)
            begin
                wgt_reg[n] <= '0;
            end
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_READ);
            rd_k_reg   <= k_reg;

            if (put_load)
            begin
                rsp_valid_reg <= 1'b1;
                value_reg     <= pend_value_reg;
                oor_reg       <= pend_oor_reg;
                last_out_reg  <= last_reg;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (command == CMD_QUERY))
                    begin
                        wgt_reg[0] <= weight_0;
                        wgt_reg[1] <= weight_1;
                        wgt_reg[2] <= weight_2;
                        wgt_reg[3] <= weight_3;
                        last_reg   <= last_point;
                        if (in_grid)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            pend_value_reg <= '0;
                            pend_oor_reg   <= 1'b1;
                            state_reg      <= ST_PUT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR:
                begin
                    base0_reg <= LW'(row) * LW'(w_eff);
                    base1_reg <= LW'(nrow) * LW'(w_eff);
                    col_reg   <= div_rem;
                    ncol_reg  <= ncol;
                    k_reg     <= '0;
                    if (edge_oor)
                    begin
                        pend_value_reg <= '0;
                        pend_oor_reg   <= 1'b1;
                        state_reg      <= ST_PUT;
                    end
                    else
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd1)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    pend_value_reg <= mac_result;
                    pend_oor_reg   <= 1'b0;
                    state_reg      <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (put_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign interpolated_value = value_reg;
    assign out_of_range       = oor_reg;
    assign last_point_out     = last_out_reg;

    // ---------------- submodules ----------------
    gbi_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (sample_value),
        .rdata (mem_rdata)
    );

    gbi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cell_index),
        .divisor   (w_eff),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    gbi_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (signed'(mem_rdata)),
        .weight (wgt_reg[rd_k_reg]),
        .result (mac_result)
    );

    // ---------------- assertions ----------------
`include "grid_bilinear_interpolator_unit_assert.svh"

    `GBI_ASSERT_NOW(a_read_after_div, state_reg == ST_READ, !div_busy)
    `GBI_ASSERT_NOW(a_oor_zero, rsp_valid && out_of_range, interpolated_value == '0)
    `GBI_ASSERT_NOW(a_rsp_from_put, $rose(rsp_valid), $past(state_reg == ST_PUT))
    `GBI_ASSERT_NEXT(a_addr_next, state_reg == ST_ADDR, state_reg == ST_READ || state_reg == ST_PUT)

endmodule

@@ rtl/core/gbi_mem.sv @@
// Single-port sample memory with registered read.
// Depends on gbi_pkg.
module gbi_mem #(
    parameter int DEPTH  = gbi_pkg::MAX_WIDTH_DEF * gbi_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [gbi_pkg::DATA_W-1:0]  wdata,
    output logic [gbi_pkg::DATA_W-1:0]  rdata
);

    logic [gbi_pkg::DATA_W-1:0] mem_array [DEPTH];
    logic [gbi_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/gbi_div.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Splits a linear cell index into row (quotient) and column (remainder). Depends on gbi_pkg.
module gbi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gbi_pkg::IDX_W-1:0]   dividend,
    input  logic [gbi_pkg::SIZE_W-1:0]  divisor,
    output logic [gbi_pkg::IDX_W-1:0]   quotient,
    output logic [gbi_pkg::SIZE_W-1:0]  remainder,
    output logic                        busy,
    output logic                        done
);

    localparam int IW    = gbi_pkg::IDX_W;
    localparam int SW    = gbi_pkg::SIZE_W;
    localparam int STEPS = 2;
    localparam int ITER  = (IW + STEPS - 1) / STEPS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [SW-1:0]    rem_reg, rem_next;
    logic [IW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [SW:0]      trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int s = 0; s < STEPS; s++)
        begin
            trial    = {rem_next, quo_next[IW-1]};
            quo_next = {quo_next[IW-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial       = trial - {1'b0, divisor};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(ITER);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

@@ rtl/core/gbi_mac.sv @@
// Shared multiplier and accumulator for the four weighted samples,
// with round half up and saturation to Q16.16. Depends on gbi_pkg.
module gbi_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gbi_pkg::mac_ctrl_t                ctrl,
    input  logic signed [gbi_pkg::DATA_W-1:0] sample,
    input  logic signed [gbi_pkg::WGT_W-1:0]  weight,
    output logic signed [gbi_pkg::DATA_W-1:0] result
);

    localparam int DW    = gbi_pkg::DATA_W;
    localparam int PW    = gbi_pkg::DATA_W + gbi_pkg::WGT_W;
    localparam int AW    = PW + 2;
    localparam int RW    = AW + 1;
    localparam int FRAC  = 16;
    localparam int QW    = RW - FRAC;

    logic signed [PW-1:0] prod_reg;
    logic                 prod_vld_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [RW-1:0] rnd;
    logic signed [QW-1:0] quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.data_vld && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.data_vld)
        begin
            prod_reg <= sample * weight;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // floor((acc + 2^15) / 2^16)
    assign rnd = RW'(acc_reg) + RW'(1 << (FRAC - 1));
    assign quo = rnd[RW-1:FRAC];

    always_comb
    begin
        if (quo[QW-1:DW-1] == {(QW-DW+1){quo[QW-1]}})
        begin
            result = quo[DW-1:0];
        end
        else if (quo[QW-1])
        begin
            result = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(DW-1){1'b1}}};
        end
    end

endmodule
